// ===== src/osh_pkg.sv =====
// ----------------------------------------------------------------------------
// Oversampled hold crossfade package
// Shared widths, fixed-point constants, register indexes and the lane
// control word.
// ----------------------------------------------------------------------------
package osh_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int RATE_W    = 40;
    localparam int FRAC_W    = 32;
    localparam int RAMP_W    = 18;
    localparam int RAMP_FRAC = 16;
    localparam int PORTS     = 4;
    localparam int CFG_W     = 3;
    localparam int CFG_IDX_W = 1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [RAMP_W-1:0]          ramp_t;

    localparam ramp_t   RAMP_ONE  = 18'h10000;
    localparam ramp_t   RAMP_HALF = 18'h08000;
    localparam ramp_t   RAMP_MAX  = 18'h3FFFF;
    localparam sample_t S24_MAX   = 24'sh7FFFFF;
    localparam sample_t S24_MIN   = 24'sh800000;

    localparam logic [CFG_IDX_W-1:0] CFG_OSL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHN = 1'b1;

    typedef struct packed {
        logic             fading;
        logic             cap_held;
        logic             cap_long;
        ramp_t            ramp;
        logic [PORTS-1:0] active;
    } lane_ctl_t;

endpackage

// ===== src/osh_if.sv =====
// ----------------------------------------------------------------------------
// Oversampled hold crossfade channels
// Valid/ready interfaces for the input frame and the output frame.
// ----------------------------------------------------------------------------
interface osh_frame_if import osh_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [RATE_W-1:0] end_rate;
    sample_t           sample_in0;
    sample_t           sample_in1;
    sample_t           sample_in2;
    sample_t           sample_in3;

    modport source (
        output valid, end_rate, sample_in0, sample_in1, sample_in2, sample_in3,
        input  ready
    );
    modport sink (
        input  valid, end_rate, sample_in0, sample_in1, sample_in2, sample_in3,
        output ready
    );
endinterface

interface osh_result_if import osh_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t sample_out0;
    sample_t sample_out1;
    sample_t sample_out2;
    sample_t sample_out3;

    modport source (
        output valid, sample_out0, sample_out1, sample_out2, sample_out3,
        input  ready
    );
    modport sink (
        input  valid, sample_out0, sample_out1, sample_out2, sample_out3,
        output ready
    );
endinterface

// ===== src/osh_ctrl.sv =====
// ----------------------------------------------------------------------------
// Oversampled hold crossfade control
// Hold timing, phase counters, fade ramp and the per-beat lane control word.
// ----------------------------------------------------------------------------
module osh_ctrl import osh_pkg::*; #(
    parameter int CHANNELS              = 4,
    parameter int FADE_SAMPLES          = 64,
    parameter int MAX_OVERSAMPLING_LOG2 = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 accept,
    input  logic [RATE_W-1:0]    end_rate,
    output lane_ctl_t            ctl
);

    localparam int EW   = (MAX_OVERSAMPLING_LOG2 < 1) ? 1 : $clog2(MAX_OVERSAMPLING_LOG2 + 1);
    localparam int PW   = (MAX_OVERSAMPLING_LOG2 < 1) ? 1 : MAX_OVERSAMPLING_LOG2;
    localparam int FW   = $clog2(FADE_SAMPLES + 1);
    localparam int NL   = (CHANNELS < PORTS) ? CHANNELS : PORTS;
    localparam int STEP = (65536 + FADE_SAMPLES / 2) / FADE_SAMPLES;
    localparam ramp_t RAMP_STEP = RAMP_W'(STEP);

    logic [CFG_W-1:0] osl_reg;
    logic [CFG_W-1:0] chn_reg;
    logic [EW-1:0]    hold_exp_reg;
    logic [EW-1:0]    sub_exp_reg;
    logic [PW-1:0]    phase_reg;
    logic [PW-1:0]    sub_phase_reg;
    logic [FW-1:0]    fade_left_reg;
    ramp_t            ramp_reg;
    logic             rising_reg;

    logic [3:0]        kmax;
    logic [RATE_W-1:0] rate_m1;
    logic [EW-1:0]     tgt_exp;
    logic              stop;
    logic              fading_old;
    logic              start;
    logic              rising_new;
    logic [EW-1:0]     lo_exp;
    logic [EW-1:0]     hi_exp;
    logic [EW-1:0]     hold_eff;
    logic [EW-1:0]     sub_eff;
    logic [PW-1:0]     sub_phase_eff;
    ramp_t             ramp_eff;
    logic              rising_eff;
    logic              fading;
    logic [FW-1:0]     fade_left_eff;
    logic [PW:0]       phase_inc;
    logic [PW:0]       sub_inc;
    logic              wrap;
    logic              sub_wrap;
    logic [RAMP_W:0]   ramp_sum;
    ramp_t             ramp_up;
    ramp_t             ramp_dn;
    logic [3:0]        chn_lim;

    logic [EW-1:0]     hold_exp_next;
    logic [PW-1:0]     phase_next;
    logic [PW-1:0]     sub_phase_next;
    logic [FW-1:0]     fade_left_next;
    ramp_t             ramp_next;

    // Target hold exponent: leading zeros of the fraction of (rate - 1),
    // capped by the oversampling setting. Zero rates and integer rates above one give zero.
    always_comb
    begin
        kmax    = ({1'b0, osl_reg} > 4'(MAX_OVERSAMPLING_LOG2)) ?
                  4'(MAX_OVERSAMPLING_LOG2) : {1'b0, osl_reg};
        rate_m1 = end_rate - RATE_W'(1);
        tgt_exp = '0;
        stop    = (rate_m1[RATE_W-1:FRAC_W] != '0);
        for (int i = 0; i < MAX_OVERSAMPLING_LOG2; i++)
        begin
            if (!stop && (4'(i) < kmax) && !rate_m1[FRAC_W-1-i])
            begin
                tgt_exp = EW'(i + 1);
            end
            else
            begin
                stop = 1'b1;
            end
        end
    end

    always_comb
    begin
        fading_old    = (fade_left_reg != '0);
        start         = !fading_old && (tgt_exp != hold_exp_reg) && (phase_reg == '0);
        rising_new    = (hold_exp_reg > tgt_exp);
        lo_exp        = rising_new ? tgt_exp : hold_exp_reg;
        hi_exp        = rising_new ? hold_exp_reg : tgt_exp;
        hold_eff      = start ? lo_exp : hold_exp_reg;
        sub_eff       = start ? (hi_exp - lo_exp) : sub_exp_reg;
        sub_phase_eff = start ? '0 : sub_phase_reg;
        ramp_eff      = start ? (rising_new ? '0 : RAMP_ONE) : ramp_reg;
        rising_eff    = start ? rising_new : rising_reg;
        fading        = fading_old || start;
        fade_left_eff = start ? FW'(FADE_SAMPLES) : fade_left_reg;

        phase_inc  = {1'b0, phase_reg} + (PW+1)'(1);
        wrap       = (phase_inc >= ((PW+1)'(1) << hold_eff));
        phase_next = wrap ? '0 : phase_inc[PW-1:0];

        sub_inc  = {1'b0, sub_phase_eff} + (PW+1)'(1);
        sub_wrap = (sub_inc >= ((PW+1)'(1) << sub_eff));
        if (wrap && fading)
        begin
            sub_phase_next = sub_wrap ? '0 : sub_inc[PW-1:0];
        end
        else
        begin
            sub_phase_next = sub_phase_eff;
        end

        ramp_sum = {1'b0, ramp_eff} + {1'b0, RAMP_STEP};
        ramp_up  = (ramp_sum > {1'b0, RAMP_MAX}) ? RAMP_MAX : ramp_sum[RAMP_W-1:0];
        ramp_dn  = (ramp_eff > RAMP_STEP) ? (ramp_eff - RAMP_STEP) : '0;
        if (fading)
        begin
            ramp_next      = rising_eff ? ramp_up : ramp_dn;
            fade_left_next = fade_left_eff - FW'(1);
        end
        else
        begin
            ramp_next      = ramp_eff;
            fade_left_next = fade_left_eff;
        end

        if (fading && (fade_left_next == '0) && (ramp_next < RAMP_HALF))
        begin
            hold_exp_next = hold_eff + sub_eff;
        end
        else
        begin
            hold_exp_next = hold_eff;
        end
    end

    always_comb
    begin
        if (chn_reg == '0)
        begin
            chn_lim = 4'd1;
        end
        else if ({1'b0, chn_reg} > 4'(NL))
        begin
            chn_lim = 4'(NL);
        end
        else
        begin
            chn_lim = {1'b0, chn_reg};
        end
        for (int c = 0; c < PORTS; c++)
        begin
            ctl.active[c] = (4'(c) < chn_lim);
        end
        ctl.fading   = fading;
        ctl.cap_held = (phase_reg == '0);
        ctl.cap_long = fading && (phase_reg == '0) && (sub_phase_eff == '0);
        ctl.ramp     = ramp_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            osl_reg       <= '0;
            chn_reg       <= CFG_W'(1);
            hold_exp_reg  <= '0;
            sub_exp_reg   <= '0;
            phase_reg     <= '0;
            sub_phase_reg <= '0;
            fade_left_reg <= '0;
            ramp_reg      <= '0;
            rising_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OSL:
                begin
                    osl_reg       <= cfg_data;
                    hold_exp_reg  <= '0;
                    phase_reg     <= '0;
                    sub_phase_reg <= '0;
                end
                CFG_CHN:
                begin
                    chn_reg       <= cfg_data;
                    phase_reg     <= '0;
                    sub_phase_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            hold_exp_reg  <= hold_exp_next;
            sub_exp_reg   <= sub_eff;
            phase_reg     <= phase_next;
            sub_phase_reg <= sub_phase_next;
            fade_left_reg <= fade_left_next;
            ramp_reg      <= ramp_next;
            rising_reg    <= rising_eff;
        end
    end

endmodule

// ===== src/osh_lane.sv =====
// ----------------------------------------------------------------------------
// Oversampled hold crossfade lane
// Held samples of one channel and a two-stage crossfade multiply-add.
// ----------------------------------------------------------------------------
module osh_lane import osh_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  logic      adv2,
    input  lane_ctl_t ctl,
    input  logic      active,
    input  sample_t   x,
    output sample_t   y
);

    localparam int DIF_W  = SAMPLE_W + 1;
    localparam int PROD_W = RAMP_W + 1 + DIF_W;
    localparam int SUM_W  = PROD_W - RAMP_FRAC + 1;
    localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) << (RAMP_FRAC - 1);

    sample_t                   held_reg;
    sample_t                   long_reg;
    logic                      s1_fade_reg;
    sample_t                   s1_long_reg;
    sample_t                   s1_plain_reg;
    logic signed [DIF_W-1:0]   s1_dif_reg;
    ramp_t                     s1_ramp_reg;
    logic                      s2_fade_reg;
    sample_t                   s2_long_reg;
    sample_t                   s2_plain_reg;
    logic signed [PROD_W-1:0]  s2_prod_reg;

    sample_t                   held_next;
    sample_t                   long_next;
    logic signed [DIF_W-1:0]   dif;
    logic signed [RAMP_W:0]    ramp_s;
    logic signed [PROD_W-1:0]  rounded;
    logic signed [PROD_W-1:0]  scaled;
    logic signed [SUM_W-1:0]   sum;
    sample_t                   sat;

    always_comb
    begin
        held_next = (active && ctl.cap_held) ? x : held_reg;
        long_next = (active && ctl.cap_long) ? x : long_reg;
        dif       = DIF_W'(held_next) - DIF_W'(long_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            long_reg <= '0;
        end
        else if (accept)
        begin
            held_reg <= held_next;
            long_reg <= long_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_fade_reg  <= active && ctl.fading;
            s1_long_reg  <= long_next;
            s1_plain_reg <= active ? held_next : x;
            s1_dif_reg   <= dif;
            s1_ramp_reg  <= ctl.ramp;
        end
    end

    assign ramp_s = signed'({1'b0, s1_ramp_reg});

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            s2_fade_reg  <= s1_fade_reg;
            s2_long_reg  <= s1_long_reg;
            s2_plain_reg <= s1_plain_reg;
            s2_prod_reg  <= ramp_s * s1_dif_reg;
        end
    end

    always_comb
    begin
        rounded = s2_prod_reg + ROUND_BIAS;
        scaled  = rounded >>> RAMP_FRAC;
        sum     = SUM_W'(scaled) + SUM_W'(s2_long_reg);
        if (sum > SUM_W'(S24_MAX))
        begin
            sat = S24_MAX;
        end
        else if (sum < SUM_W'(S24_MIN))
        begin
            sat = S24_MIN;
        end
        else
        begin
            sat = sum[SAMPLE_W-1:0];
        end
        y = s2_fade_reg ? sat : s2_plain_reg;
    end

endmodule

// ===== src/oversampled_hold_crossfade.sv =====
// ----------------------------------------------------------------------------
// Oversampled hold crossfade
// Sample-and-hold of an oversampled multichannel stream with crossfaded
// changes of hold time.
// ----------------------------------------------------------------------------
// Usage:
// The frame channel carries one oversampled frame per beat: the block end
// rate and four signed 24-bit samples. The result channel returns one frame
// per accepted frame, in order. Channels at or beyond the active channel
// count pass straight through. The user must write the configuration port
// only while no frame is in flight; the block does not enforce this. Each
// write restarts the hold phase. Throughput is one frame per cycle while the
// receiver is ready: the hold state is updated when a frame is accepted,
// each lane then registers the ramp multiplication, and the rounding,
// add and saturation feed the output register, which merges the lanes.
// When the receiver stalls, the output holds and the earlier stages keep
// accepting until the pipeline is full, after which ready falls.
// Reset clears all hold and fade state and empties the pipeline.
// ----------------------------------------------------------------------------
module oversampled_hold_crossfade import osh_pkg::*; #(
    parameter int CHANNELS              = 4,
    parameter int FADE_SAMPLES          = 64,
    parameter int MAX_OVERSAMPLING_LOG2 = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    osh_frame_if.sink            frame,
    osh_result_if.source         result
);

    logic      v1_reg;
    logic      v2_reg;
    logic      v3_reg;
    logic      adv1;
    logic      adv2;
    logic      adv3;
    logic      accept;
    lane_ctl_t ctl;
    sample_t   x_w   [PORTS];
    sample_t   y_w   [PORTS];
    sample_t   out_reg [PORTS];

    assign adv3   = !v3_reg || result.ready;
    assign adv2   = !v2_reg || adv3;
    assign adv1   = !v1_reg || adv2;
    assign accept = frame.valid && adv1;

    assign frame.ready  = adv1;
    assign result.valid = v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= frame.valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    osh_ctrl #(
        .CHANNELS              (CHANNELS),
        .FADE_SAMPLES          (FADE_SAMPLES),
        .MAX_OVERSAMPLING_LOG2 (MAX_OVERSAMPLING_LOG2)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .end_rate  (frame.end_rate),
        .ctl       (ctl)
    );

    assign x_w[0] = frame.sample_in0;
    assign x_w[1] = frame.sample_in1;
    assign x_w[2] = frame.sample_in2;
    assign x_w[3] = frame.sample_in3;

    for (genvar c = 0; c < PORTS; c++)
    begin : g_lane
        if (c < CHANNELS)
        begin : g_hold
            osh_lane u_lane (
                .clk    (clk),
                .rst_n  (rst_n),
                .accept (accept),
                .adv2   (adv2),
                .ctl    (ctl),
                .active (ctl.active[c]),
                .x      (x_w[c]),
                .y      (y_w[c])
            );
        end
        else
        begin : g_pass
            sample_t d1_reg;
            sample_t d2_reg;

            always_ff @(posedge clk)
            begin
                if (accept)
                begin
                    d1_reg <= x_w[c];
                end
                if (adv2)
                begin
                    d2_reg <= d1_reg;
                end
            end

            assign y_w[c] = d2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            for (int c = 0; c < PORTS; c++)
            begin
                out_reg[c] <= y_w[c];
            end
        end
    end

    assign result.sample_out0 = out_reg[0];
    assign result.sample_out1 = out_reg[1];
    assign result.sample_out2 = out_reg[2];
    assign result.sample_out3 = out_reg[3];

endmodule

// ===== src/osh_checker.sv =====
// ----------------------------------------------------------------------------
// Oversampled hold crossfade port checks
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module osh_checker import osh_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    frame_valid,
    input logic    frame_ready,
    input logic    result_valid,
    input logic    result_ready,
    input sample_t sample_out0,
    input sample_t sample_out1,
    input sample_t sample_out2,
    input sample_t sample_out3
);

    // A stalled result beat stays offered.
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result beat withdrawn while stalled");

    // A stalled result beat keeps its samples.
    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            $stable(sample_out0) && $stable(sample_out1) &&
            $stable(sample_out2) && $stable(sample_out3))
        else $error("result samples changed while stalled");

    // A new result appears only for an accepted frame.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(frame_valid && frame_ready, 3))
        else $error("result beat without a matching frame");

    // With the receiver ready, an accepted frame yields its result.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && frame_ready) ##1 result_ready ##1 result_ready |=> result_valid)
        else $error("result beat late");

endmodule

bind oversampled_hold_crossfade osh_checker u_osh_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_valid  (frame.valid),
    .frame_ready  (frame.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .sample_out0  (result.sample_out0),
    .sample_out1  (result.sample_out1),
    .sample_out2  (result.sample_out2),
    .sample_out3  (result.sample_out3)
);
